FILE: rtl/dlr_pkg.sv
// dlr_pkg: shared types and constants of the ring hash table routing engine
// no dependencies; used by the interfaces, the top level and the checker
package dlr_pkg;

    localparam int CACHE_ENTRIES = 10;
    localparam int CIDX_W        = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int ID_W          = 16;
    localparam int IP_W          = 32;
    localparam int PORT_W        = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_REPLY  = 2'd1,
        OP_QUERY  = 2'd2,
        OP_OTHER  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ACT_REPLY    = 3'd0,
        ACT_FORWARD  = 3'd1,
        ACT_STORED   = 3'd2,
        ACT_LOCAL    = 3'd3,
        ACT_REDIRECT = 3'd4,
        ACT_BUSY     = 3'd5,
        ACT_IGNORED  = 3'd6
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NODE_ID   = 3'd0,
        REG_PRED_ID   = 3'd1,
        REG_SUCC_ID   = 3'd2,
        REG_NODE_IP   = 3'd3,
        REG_NODE_PORT = 3'd4,
        REG_SUCC_IP   = 3'd5,
        REG_SUCC_PORT = 3'd6
    } cfg_reg_t;

    localparam logic OUT_TYPE_LOOKUP = 1'b0;
    localparam logic OUT_TYPE_REPLY  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OWN,
        ST_SUCC,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        action_t           action;
        logic              out_type;
        logic [ID_W-1:0]   out_key;
        logic [ID_W-1:0]   out_peer_id;
        logic [IP_W-1:0]   out_peer_ip;
        logic [PORT_W-1:0] out_peer_port;
        logic [IP_W-1:0]   dest_ip;
        logic [PORT_W-1:0] dest_port;
    } res_t;

endpackage

FILE: rtl/dlr_if.sv
// dlr_event_if / dlr_result_if: valid/ready channels of the routing engine
// depends on dlr_pkg for field widths
interface dlr_event_if
    import dlr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [ID_W-1:0]   key_hash;
    logic [ID_W-1:0]   peer_id;
    logic [IP_W-1:0]   peer_ip;
    logic [PORT_W-1:0] peer_port;
    logic [IP_W-1:0]   source_ip;
    logic [PORT_W-1:0] source_port;

    modport source (
        output valid, operation, key_hash, peer_id, peer_ip, peer_port,
               source_ip, source_port,
        input  ready
    );
    modport sink (
        input  valid, operation, key_hash, peer_id, peer_ip, peer_port,
               source_ip, source_port,
        output ready
    );
endinterface

interface dlr_result_if
    import dlr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic              out_type;
    logic [ID_W-1:0]   out_key;
    logic [ID_W-1:0]   out_peer_id;
    logic [IP_W-1:0]   out_peer_ip;
    logic [PORT_W-1:0] out_peer_port;
    logic [IP_W-1:0]   dest_ip;
    logic [PORT_W-1:0] dest_port;

    modport source (
        output valid, action, out_type, out_key, out_peer_id, out_peer_ip,
               out_peer_port, dest_ip, dest_port,
        input  ready
    );
    modport sink (
        input  valid, action, out_type, out_key, out_peer_id, out_peer_ip,
               out_peer_port, dest_ip, dest_port,
        output ready
    );
endinterface

FILE: rtl/dht_lookup_router.sv
// dht_lookup_router: routing decision engine of one ring hash table node
// depends on dlr_pkg and the channel interfaces in dlr_if.sv
//
// one event is taken at a time on the request channel and exactly one
// decision leaves on the decision channel. a single ring-interval comparator
// (lo, hi] with wrap-around is reused under a small sequencer: the ownership
// test against the predecessor, then the successor test for a lookup, or a
// walk over the reply cache one entry per cycle for a routing query. an
// event holds request.ready low from its transfer until its decision is
// loaded into the output register; a routing query can take longest, the
// cache walk being the dominant term. the output register lets the next
// event be taken while a decision still waits on the sink. the cache
// holds the newest CACHE_ENTRIES replies, entry 0 newest, in a shift
// line with a valid bit per entry. configuration writes are expected only
// while the engine is idle
module dht_lookup_router
    import dlr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    dlr_event_if.sink             request,
    dlr_result_if.source          decision
);

    // configuration
    logic [ID_W-1:0]   node_id_reg;
    logic [ID_W-1:0]   pred_id_reg;
    logic [ID_W-1:0]   succ_id_reg;
    logic [IP_W-1:0]   node_ip_reg;
    logic [PORT_W-1:0] node_port_reg;
    logic [IP_W-1:0]   succ_ip_reg;
    logic [PORT_W-1:0] succ_port_reg;

    // sequencer
    state_t            state_reg, state_next;
    logic [CIDX_W-1:0] idx_reg, idx_next;
    res_t              pend_reg, pend_next;

    // captured event
    op_t               op_reg;
    logic [ID_W-1:0]   key_reg;
    logic [ID_W-1:0]   pid_reg;
    logic [IP_W-1:0]   pip_reg;
    logic [PORT_W-1:0] pport_reg;
    logic [IP_W-1:0]   sip_reg;
    logic [PORT_W-1:0] sport_reg;

    // reply cache, entry 0 newest
    logic                     cache_valid_reg [CACHE_ENTRIES];
    logic [2*ID_W-1:0]        cache_range_mem [CACHE_ENTRIES];
    logic [IP_W+PORT_W-1:0]   cache_addr_mem  [CACHE_ENTRIES];

    // output register
    logic dec_valid_reg, dec_valid_next;
    res_t dec_reg;
    logic dec_load;

    logic req_fire;
    logic cache_push;

    // shared ring comparator
    logic [ID_W-1:0] cmp_lo, cmp_hi;
    logic            cmp_hit;
    logic            chain3;

    assign req_fire   = request.valid && request.ready;
    assign cache_push = req_fire && (op_t'(request.operation) == OP_REPLY);
    assign request.ready = (state_reg == ST_IDLE);

    // configuration writes, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg   <= '0;
            pred_id_reg   <= '0;
            succ_id_reg   <= '0;
            node_ip_reg   <= '0;
            node_port_reg <= '0;
            succ_ip_reg   <= '0;
            succ_port_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NODE_ID:   node_id_reg   <= cfg_data[ID_W-1:0];
                REG_PRED_ID:   pred_id_reg   <= cfg_data[ID_W-1:0];
                REG_SUCC_ID:   succ_id_reg   <= cfg_data[ID_W-1:0];
                REG_NODE_IP:   node_ip_reg   <= cfg_data[IP_W-1:0];
                REG_NODE_PORT: node_port_reg <= cfg_data[PORT_W-1:0];
                REG_SUCC_IP:   succ_ip_reg   <= cfg_data[IP_W-1:0];
                REG_SUCC_PORT: succ_port_reg <= cfg_data[PORT_W-1:0];
                default:       ;
            endcase
        end
    end

    // event capture
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg    <= op_t'(request.operation);
            key_reg   <= request.key_hash;
            pid_reg   <= request.peer_id;
            pip_reg   <= request.peer_ip;
            pport_reg <= request.peer_port;
            sip_reg   <= request.source_ip;
            sport_reg <= request.source_port;
        end
    end

    // cache valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                cache_valid_reg[i] <= 1'b0;
            end
        end
        else if (cache_push)
        begin
            for (int i = CACHE_ENTRIES - 1; i > 0; i--)
            begin
                cache_valid_reg[i] <= cache_valid_reg[i-1];
            end
            cache_valid_reg[0] <= 1'b1;
        end
    end

    // cache payload, shifted down one place per stored reply
    always_ff @(posedge clk)
    begin
        if (cache_push)
        begin
            for (int i = CACHE_ENTRIES - 1; i > 0; i--)
            begin
                cache_range_mem[i] <= cache_range_mem[i-1];
                cache_addr_mem[i]  <= cache_addr_mem[i-1];
            end
            cache_range_mem[0] <= {request.key_hash, request.peer_id};
            cache_addr_mem[0]  <= {request.peer_ip, request.peer_port};
        end
    end

    // operand select for the comparator
    always_comb
    begin
        unique case (state_reg)
            ST_SUCC:
            begin
                cmp_lo = node_id_reg;
                cmp_hi = succ_id_reg;
            end
            ST_SCAN:
            begin
                cmp_lo = cache_range_mem[idx_reg][2*ID_W-1:ID_W];
                cmp_hi = cache_range_mem[idx_reg][ID_W-1:0];
            end
            default:
            begin
                cmp_lo = pred_id_reg;
                cmp_hi = node_id_reg;
            end
        endcase
    end

    // half-open wrapping interval; lo == hi covers the whole ring
    always_comb
    begin
        if (cmp_lo < cmp_hi)
        begin
            cmp_hit = (cmp_lo < key_reg) && (key_reg <= cmp_hi);
        end
        else
        begin
            cmp_hit = (cmp_lo < key_reg) || (key_reg <= cmp_hi);
        end
    end

    // three-node chain pred, node, succ consecutive on the ring
    assign chain3 = (ID_W'(pred_id_reg + 1'b1) == node_id_reg)
                 && (ID_W'(node_id_reg + 1'b1) == succ_id_reg);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    pend_next = '0;
                    idx_next  = '0;
                    unique case (op_t'(request.operation))
                        OP_LOOKUP: state_next = ST_OWN;
                        OP_QUERY:  state_next = ST_OWN;
                        OP_REPLY:
                        begin
                            pend_next.action = ACT_STORED;
                            state_next       = ST_FINISH;
                        end
                        default:
                        begin
                            pend_next.action = ACT_IGNORED;
                            state_next       = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_OWN:
            begin
                if (op_reg == OP_LOOKUP)
                begin
                    if (cmp_hit)
                    begin
                        pend_next.action        = ACT_REPLY;
                        pend_next.out_type      = OUT_TYPE_REPLY;
                        pend_next.out_key       = pred_id_reg;
                        pend_next.out_peer_id   = node_id_reg;
                        pend_next.out_peer_ip   = node_ip_reg;
                        pend_next.out_peer_port = node_port_reg;
                        pend_next.dest_ip       = sip_reg;
                        pend_next.dest_port     = sport_reg;
                        state_next              = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SUCC;
                    end
                end
                else if (cmp_hit)
                begin
                    pend_next.action = ACT_LOCAL;
                    state_next       = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end

            ST_SUCC:
            begin
                pend_next.dest_ip   = sip_reg;
                pend_next.dest_port = sport_reg;
                if (cmp_hit)
                begin
                    pend_next.action        = ACT_REPLY;
                    pend_next.out_type      = OUT_TYPE_REPLY;
                    pend_next.out_key       = node_id_reg;
                    pend_next.out_peer_id   = succ_id_reg;
                    pend_next.out_peer_ip   = succ_ip_reg;
                    pend_next.out_peer_port = succ_port_reg;
                end
                else
                begin
                    // forward the message unchanged to the successor
                    pend_next.action        = ACT_FORWARD;
                    pend_next.out_type      = OUT_TYPE_LOOKUP;
                    pend_next.out_key       = key_reg;
                    pend_next.out_peer_id   = pid_reg;
                    pend_next.out_peer_ip   = pip_reg;
                    pend_next.out_peer_port = pport_reg;
                    pend_next.dest_ip       = succ_ip_reg;
                    pend_next.dest_port     = succ_port_reg;
                end
                state_next = ST_FINISH;
            end

            ST_SCAN:
            begin
                if (cache_valid_reg[idx_reg] && cmp_hit)
                begin
                    pend_next.action    = ACT_REDIRECT;
                    pend_next.dest_ip   = cache_addr_mem[idx_reg][IP_W+PORT_W-1:PORT_W];
                    pend_next.dest_port = cache_addr_mem[idx_reg][PORT_W-1:0];
                    state_next          = ST_FINISH;
                end
                else if (idx_reg == CIDX_W'(CACHE_ENTRIES - 1))
                begin
                    pend_next.dest_ip   = succ_ip_reg;
                    pend_next.dest_port = succ_port_reg;
                    if (chain3)
                    begin
                        pend_next.action        = ACT_BUSY;
                        pend_next.out_type      = OUT_TYPE_LOOKUP;
                        pend_next.out_key       = key_reg;
                        pend_next.out_peer_id   = node_id_reg;
                        pend_next.out_peer_ip   = node_ip_reg;
                        pend_next.out_peer_port = node_port_reg;
                    end
                    else
                    begin
                        pend_next.action = ACT_REDIRECT;
                    end
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_FINISH:
            begin
                if (dec_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    // output register
    assign dec_load       = (state_reg == ST_FINISH) && (!dec_valid_reg || decision.ready);
    assign dec_valid_next = dec_load || (dec_valid_reg && !decision.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_valid_reg <= 1'b0;
        end
        else
        begin
            dec_valid_reg <= dec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_load)
        begin
            dec_reg <= pend_reg;
        end
    end

    assign decision.valid         = dec_valid_reg;
    assign decision.action        = dec_reg.action;
    assign decision.out_type      = dec_reg.out_type;
    assign decision.out_key       = dec_reg.out_key;
    assign decision.out_peer_id   = dec_reg.out_peer_id;
    assign decision.out_peer_ip   = dec_reg.out_peer_ip;
    assign decision.out_peer_port = dec_reg.out_peer_port;
    assign decision.dest_ip       = dec_reg.dest_ip;
    assign decision.dest_port     = dec_reg.dest_port;

endmodule

FILE: rtl/dlr_checker.sv
// dlr_checker: port-level assertions on the routing engine, bound to the top
// depends on dlr_pkg and dht_lookup_router
module dlr_checker
    import dlr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       dec_valid,
    input logic       dec_ready,
    input logic [2:0] dec_action,
    input logic       dec_out_type
);

    // one event at a time: busy right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while previous event still in work");

    // only a reply decision carries the reply message type
    assert property (@(posedge clk) disable iff (!rst_n)
        (dec_valid && dec_out_type) |-> (dec_action == ACT_REPLY))
        else $error("reply type on a non-reply decision");

    // stalled decision stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        (dec_valid && !dec_ready) |=> dec_valid)
        else $error("decision dropped while stalled");

    // stalled decision holds its action
    assert property (@(posedge clk) disable iff (!rst_n)
        (dec_valid && !dec_ready) |=> $stable(dec_action))
        else $error("decision action changed while stalled");

endmodule

bind dht_lookup_router dlr_checker u_dlr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (request.valid),
    .req_ready    (request.ready),
    .dec_valid    (decision.valid),
    .dec_ready    (decision.ready),
    .dec_action   (decision.action),
    .dec_out_type (decision.out_type)
);

FILE: tb/tb_dht_lookup_router.sv
`timescale 1ns / 100ps
// tb_dht_lookup_router: self-checking bench for the ring hash table routing engine
// depends on dlr_pkg, the channel interfaces in dlr_if.sv and dht_lookup_router
module tb_dht_lookup_router;
    import dlr_pkg::*;

    localparam int                   WATCHDOG_LIMIT = 2000;
    localparam int                   SETTLE_CYCLES  = 20;
    localparam int                   MAX_REPORTS    = 10;
    // index past the end of the register list, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] UNUSED_REG_IDX = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dlr_event_if  req_ch ();
    dlr_result_if dec_ch ();

    dht_lookup_router uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (req_ch),
        .decision  (dec_ch)
    );

    // bench copy of the ring registers
    logic [ID_W-1:0]   ring_node;
    logic [ID_W-1:0]   ring_pred;
    logic [ID_W-1:0]   ring_succ;
    logic [IP_W-1:0]   own_ip;
    logic [PORT_W-1:0] own_port;
    logic [IP_W-1:0]   next_ip;
    logic [PORT_W-1:0] next_port;

    // bench copy of the reply cache, entry 0 newest
    logic              cached_valid [CACHE_ENTRIES];
    logic [31:0]       cached_arc   [CACHE_ENTRIES];
    logic [47:0]       cached_addr  [CACHE_ENTRIES];

    res_t              pending_decisions [$];
    int                fault_count;
    bit                idling;
    int                stall_left;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // half-open ring arc (lo, hi] with wrap, lo == hi is the whole ring
    function automatic bit on_arc(input logic [ID_W-1:0] lo, hi, x);
        if (lo < hi)
            return (x > lo) && (x <= hi);
        return (x > lo) || (x <= hi);
    endfunction

    // routing decision for one event; a reply also updates the cache copy
    function automatic res_t route_event(input op_t op, input logic [ID_W-1:0] key, pid,
                                         input logic [IP_W-1:0] pip,
                                         input logic [PORT_W-1:0] pport,
                                         input logic [IP_W-1:0] sip,
                                         input logic [PORT_W-1:0] sport);
        res_t            r;
        bit              hit;
        logic [ID_W-1:0] pred_next;
        logic [ID_W-1:0] node_next;
        r         = '0;
        hit       = 1'b0;
        pred_next = ring_pred + 16'd1;
        node_next = ring_node + 16'd1;
        case (op)
            OP_LOOKUP:
            begin
                if (on_arc(ring_pred, ring_node, key))
                    r = '{ACT_REPLY, OUT_TYPE_REPLY, ring_pred, ring_node, own_ip, own_port,
                          sip, sport};
                else if (on_arc(ring_node, ring_succ, key))
                    r = '{ACT_REPLY, OUT_TYPE_REPLY, ring_node, ring_succ, next_ip, next_port,
                          sip, sport};
                else
                    r = '{ACT_FORWARD, OUT_TYPE_LOOKUP, key, pid, pip, pport,
                          next_ip, next_port};
            end
            OP_REPLY:
            begin
                for (int i = CACHE_ENTRIES - 1; i > 0; i--)
                begin
                    cached_valid[i] = cached_valid[i-1];
                    cached_arc[i]   = cached_arc[i-1];
                    cached_addr[i]  = cached_addr[i-1];
                end
                cached_valid[0] = 1'b1;
                cached_arc[0]   = {key, pid};
                cached_addr[0]  = {pip, pport};
                r.action        = ACT_STORED;
            end
            OP_QUERY:
            begin
                if (on_arc(ring_pred, ring_node, key))
                    r.action = ACT_LOCAL;
                else
                begin
                    // newest covering entry wins
                    for (int i = 0; i < CACHE_ENTRIES; i++)
                    begin
                        if (!hit && cached_valid[i] &&
                            on_arc(cached_arc[i][31:16], cached_arc[i][15:0], key))
                        begin
                            hit         = 1'b1;
                            r.action    = ACT_REDIRECT;
                            r.dest_ip   = cached_addr[i][47:16];
                            r.dest_port = cached_addr[i][15:0];
                        end
                    end
                    if (!hit && pred_next == ring_node && node_next == ring_succ)
                        r = '{ACT_BUSY, OUT_TYPE_LOOKUP, key, ring_node, own_ip, own_port,
                              next_ip, next_port};
                    else if (!hit)
                    begin
                        r.action    = ACT_REDIRECT;
                        r.dest_ip   = next_ip;
                        r.dest_port = next_port;
                    end
                end
            end
            default:
                r.action = ACT_IGNORED;
        endcase
        return r;
    endfunction

    function automatic string show(input res_t r);
        return $sformatf("act=%0d type=%0d key=%h peer=%h/%h:%h dest=%h:%h",
                         r.action, r.out_type, r.out_key, r.out_peer_id, r.out_peer_ip,
                         r.out_peer_port, r.dest_ip, r.dest_port);
    endfunction

    function automatic void note_fault(input string what, input res_t want, input res_t got);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%0t %s: expected %s, got %s", $realtime, what, show(want), show(got));
    endfunction

    // 0 or all ones now and then, random otherwise
    function automatic logic [31:0] pick_field(input int bits);
        logic [31:0] mask;
        mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return mask;
            default: return $urandom & mask;
        endcase
    endfunction

    // sixteen-bit field, same mix of corner and random values
    function automatic logic [15:0] pick_short();
        logic [31:0] v;
        v = pick_field(16);
        return v[15:0];
    endfunction

    // keys clustered on the arc edges currently in force, so every branch gets hit
    function automatic logic [ID_W-1:0] probe_key();
        int slot;
        slot = $urandom_range(0, CACHE_ENTRIES - 1);
        case ($urandom_range(0, 6))
            0: return ID_W'(ring_pred + $urandom_range(0, 1));
            1: return ID_W'(ring_node + $urandom_range(0, 1));
            2: return ID_W'(ring_succ + $urandom_range(0, 1));
            3: return cached_valid[slot] ?
                      ID_W'(cached_arc[slot][31:16] + $urandom_range(0, 1)) : ID_W'($urandom);
            4: return cached_valid[slot] ?
                      ID_W'(cached_arc[slot][15:0] + $urandom_range(0, 1)) : ID_W'($urandom);
            default: return ID_W'($urandom);
        endcase
    endfunction

    // one transfer on the request channel, prediction taken at the accepting edge
    task automatic send_event(input op_t op, input logic [ID_W-1:0] key, pid,
                              input logic [IP_W-1:0] pip, input logic [PORT_W-1:0] pport,
                              input logic [IP_W-1:0] sip, input logic [PORT_W-1:0] sport);
        if (idling && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 10)) @(negedge clk);
        req_ch.operation   = op;
        req_ch.key_hash    = key;
        req_ch.peer_id     = pid;
        req_ch.peer_ip     = pip;
        req_ch.peer_port   = pport;
        req_ch.source_ip   = sip;
        req_ch.source_port = sport;
        req_ch.valid       = 1'b1;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        pending_decisions.push_back(route_event(op, key, pid, pip, pport, sip, sport));
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    // hold the sender back until every decision is home, then let the channels settle
    task automatic wait_drained(input int settle);
        while (pending_decisions.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        case (idx)
            REG_NODE_ID:   ring_node = data[ID_W-1:0];
            REG_PRED_ID:   ring_pred = data[ID_W-1:0];
            REG_SUCC_ID:   ring_succ = data[ID_W-1:0];
            REG_NODE_IP:   own_ip    = data[IP_W-1:0];
            REG_NODE_PORT: own_port  = data[PORT_W-1:0];
            REG_SUCC_IP:   next_ip   = data[IP_W-1:0];
            REG_SUCC_PORT: next_port = data[PORT_W-1:0];
            default: ;
        endcase
    endtask

    // all seven registers; narrow ones carry random upper bits that must be dropped
    task automatic load_ring(input logic [ID_W-1:0] node, pred, succ,
                             input logic [IP_W-1:0] nip, input logic [PORT_W-1:0] nport,
                             input logic [IP_W-1:0] sip, input logic [PORT_W-1:0] sport);
        write_reg(REG_NODE_ID,   {16'($urandom), node});
        write_reg(REG_PRED_ID,   {16'($urandom), pred});
        write_reg(REG_SUCC_ID,   {16'($urandom), succ});
        write_reg(REG_NODE_IP,   nip);
        write_reg(REG_NODE_PORT, {16'($urandom), nport});
        write_reg(REG_SUCC_IP,   sip);
        write_reg(REG_SUCC_PORT, {16'($urandom), sport});
        if ($urandom_range(0, 3) == 0)
            write_reg(UNUSED_REG_IDX, $urandom);
    endtask

    task automatic random_ring_config(input int mode);
        logic [ID_W-1:0] n;
        n = ID_W'($urandom);
        case (mode)
            0: load_ring(16'h0000, 16'h0000, 16'h0000, 32'h0, 16'h0, 32'h0, 16'h0);
            1: load_ring(16'hFFFF, 16'hFFFF, 16'hFFFF, '1, '1, '1, '1);
            2: load_ring(n, ID_W'($urandom), ID_W'($urandom), $urandom, PORT_W'($urandom),
                         $urandom, PORT_W'($urandom));
            3:
            begin
                // three-node chain, sometimes straddling the wrap point
                if ($urandom_range(0, 1) == 0)
                    n = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0000;
                load_ring(n, n - 16'd1, n + 16'd1, $urandom, PORT_W'($urandom),
                          $urandom, PORT_W'($urandom));
            end
            // predecessor equal to this node: the whole ring is owned here
            4: load_ring(n, n, ID_W'(n + $urandom_range(1, 4000)), $urandom,
                         PORT_W'($urandom), $urandom, PORT_W'($urandom));
            default: load_ring(n, ID_W'(n - $urandom_range(1, 3000)),
                               ID_W'(n + $urandom_range(1, 3000)),
                               $urandom, PORT_W'($urandom), $urandom, PORT_W'($urandom));
        endcase
    endtask

    // registers still at reset: pred == node == 0 so every key is owned here
    task automatic test_reset_defaults();
        send_event(OP_LOOKUP, 16'h1234, 16'h5678, 32'h0102_0304, 16'h0506,
                   32'h0A0B_0C0D, 16'h0E0F);
        send_event(OP_QUERY, 16'h0000, 16'h0000, 32'h0, 16'h0, 32'h0, 16'h0);
    endtask

    // ownership edges of both arcs, forwarding, an unknown op, a query redirect, and an arc that wraps through zero
    task automatic test_lookup_routing();
        wait_drained(4);
        load_ring(16'h1000, 16'h0800, 16'h2000, 32'hFFFF_FFFF, 16'hFFFF,
                  32'hC0A8_0001, 16'h1F90);
        write_reg(UNUSED_REG_IDX, '1);
        send_event(OP_LOOKUP, 16'h1000, pick_short(), pick_field(32), pick_short(),
                   32'hC0A8_0102, 16'h3039);
        send_event(OP_LOOKUP, 16'h0801, pick_short(), pick_field(32), pick_short(),
                   pick_field(32), pick_short());
        send_event(OP_LOOKUP, 16'h0800, 16'hABCD, 32'h1111_2222, 16'h3333,
                   pick_field(32), pick_short());
        send_event(OP_LOOKUP, 16'h2000, pick_short(), pick_field(32), pick_short(),
                   pick_field(32), pick_short());
        send_event(OP_LOOKUP, 16'h2001, pick_short(), pick_field(32), pick_short(),
                   pick_field(32), pick_short());
        send_event(OP_LOOKUP, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                   32'hFFFF_FFFF, 16'hFFFF);
        send_event(OP_LOOKUP, 16'h0000, 16'h0000, 32'h0, 16'h0, 32'h0, 16'h0);
        send_event(OP_OTHER, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                   32'hFFFF_FFFF, 16'hFFFF);
        // empty cache, not a chain: redirect to the successor
        send_event(OP_QUERY, 16'h3000, pick_short(), pick_field(32), pick_short(),
                   pick_field(32), pick_short());
        wait_drained(4);
        write_reg(REG_PRED_ID, 32'h0000_FFF0);
        write_reg(REG_NODE_ID, 32'h0000_0010);
        write_reg(REG_SUCC_ID, 32'h0000_0100);
        send_event(OP_LOOKUP, 16'h0000, pick_short(), pick_field(32), pick_short(),
                   pick_field(32), pick_short());
        send_event(OP_LOOKUP, 16'hFFF0, pick_short(), pick_field(32), pick_short(),
                   pick_field(32), pick_short());
        send_event(OP_LOOKUP, 16'h0010, pick_short(), pick_field(32), pick_short(),
                   pick_field(32), pick_short());
        send_event(OP_LOOKUP, 16'h0100, pick_short(), pick_field(32), pick_short(),
                   pick_field(32), pick_short());
    endtask

    // chain across the wrap point, cache hits incl. a wrapping arc and a whole-ring arc
    task automatic test_query_paths();
        wait_drained(4);
        load_ring(16'hFFFF, 16'hFFFE, 16'h0000, 32'h0A00_0001, 16'h0050,
                  32'h0A00_0002, 16'h0051);
        send_event(OP_QUERY, 16'h0005, pick_short(), pick_field(32), pick_short(),
                   pick_field(32), pick_short());
        send_event(OP_QUERY, 16'hFFFF, pick_short(), pick_field(32), pick_short(),
                   pick_field(32), pick_short());
        send_event(OP_REPLY, 16'h2F00, 16'h3100, 32'h0A00_0003, 16'h0100,
                   pick_field(32), pick_short());
        send_event(OP_QUERY, 16'h3000, pick_short(), pick_field(32), pick_short(),
                   pick_field(32), pick_short());
        send_event(OP_QUERY, 16'h3101, pick_short(), pick_field(32), pick_short(),
                   pick_field(32), pick_short());
        send_event(OP_REPLY, 16'hFFF0, 16'h0010, 32'h0A00_0004, 16'h0200,
                   pick_field(32), pick_short());
        send_event(OP_QUERY, 16'h0005, pick_short(), pick_field(32), pick_short(),
                   pick_field(32), pick_short());
        send_event(OP_REPLY, 16'h4000, 16'h4000, 32'h0A00_0005, 16'h0300,
                   pick_field(32), pick_short());
        send_event(OP_QUERY, 16'h2F80, pick_short(), pick_field(32), pick_short(),
                   pick_field(32), pick_short());
    endtask

    // random phases, each under a fresh ring setting; replies keep the cache churning
    task automatic test_random_traffic(input int first_phase, last_phase, per_phase);
        logic [ID_W-1:0] lo;
        logic [ID_W-1:0] hi;
        for (int ph = first_phase; ph <= last_phase; ph++)
        begin
            wait_drained(4);
            random_ring_config(ph % 6);
            for (int n = 0; n < per_phase; n++)
            begin
                // sender holds off mid-phase until the engine has caught up
                if (ph % 3 == 0 && n == per_phase / 2)
                    wait_drained(0);
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5:
                        send_event(OP_LOOKUP, probe_key(), pick_short(), pick_field(32),
                                   pick_short(), pick_field(32), pick_short());
                    6, 7, 8, 9, 10, 11:
                    begin
                        lo = ID_W'($urandom);
                        case ($urandom_range(0, 7))
                            0:       hi = lo;
                            1, 2:    hi = ID_W'($urandom);
                            default: hi = ID_W'(lo + $urandom_range(1, 2000));
                        endcase
                        send_event(OP_REPLY, lo, hi, pick_field(32), pick_short(),
                                   pick_field(32), pick_short());
                    end
                    19:
                        send_event(OP_OTHER, pick_short(), pick_short(), pick_field(32),
                                   pick_short(), pick_field(32), pick_short());
                    default:
                        send_event(OP_QUERY, probe_key(), pick_short(), pick_field(32),
                                   pick_short(), pick_field(32), pick_short());
                endcase
            end
        end
    endtask

    // decision channel backpressure in random bursts, started only while idling is set
    initial
    begin : sink_stalls
        dec_ch.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                dec_ch.ready = 1'b0;
                stall_left--;
            end
            else if (idling && $urandom_range(0, 5) == 0)
            begin
                dec_ch.ready = 1'b0;
                stall_left   = $urandom_range(0, 9);
            end
            else
                dec_ch.ready = 1'b1;
        end
    end

    // every decision transfer is matched against the oldest prediction
    always @(posedge clk)
    begin : decision_check
        res_t got;
        res_t want;
        if (dec_ch.valid === 1'b1 && dec_ch.ready === 1'b1)
        begin
            got = '{action_t'(dec_ch.action), dec_ch.out_type, dec_ch.out_key,
                    dec_ch.out_peer_id, dec_ch.out_peer_ip, dec_ch.out_peer_port,
                    dec_ch.dest_ip, dec_ch.dest_port};
            if (pending_decisions.size() == 0)
                note_fault("decision with nothing pending", '0, got);
            else
            begin
                want = pending_decisions.pop_front();
                if (got.action !== want.action || got.out_type !== want.out_type ||
                    got.out_key !== want.out_key || got.out_peer_id !== want.out_peer_id ||
                    got.out_peer_ip !== want.out_peer_ip ||
                    got.out_peer_port !== want.out_peer_port ||
                    got.dest_ip !== want.dest_ip || got.dest_port !== want.dest_port)
                    note_fault("decision mismatch", want, got);
            end
        end
    end

    // ends the run when neither channel has seen a transfer for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (dec_ch.valid === 1'b1 && dec_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_dht_lookup_router: done, errors");
        $finish;
    end

    initial
    begin : run
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.operation   = OP_LOOKUP;
        req_ch.key_hash    = '0;
        req_ch.peer_id     = '0;
        req_ch.peer_ip     = '0;
        req_ch.peer_port   = '0;
        req_ch.source_ip   = '0;
        req_ch.source_port = '0;
        ring_node          = '0;
        ring_pred          = '0;
        ring_succ          = '0;
        own_ip             = '0;
        own_port           = '0;
        next_ip            = '0;
        next_port          = '0;
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            cached_valid[i] = 1'b0;
            cached_arc[i]   = '0;
            cached_addr[i]  = '0;
        end
        fault_count = 0;
        idling      = 1'b1;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_lookup_routing();
        test_query_paths();
        test_random_traffic(0, 7, 95);
        // closing stretch at full rate on both sides
        idling = 1'b0;
        test_random_traffic(8, 9, 95);

        wait_drained(SETTLE_CYCLES);
        if (fault_count == 0)
            $display("tb_dht_lookup_router: done, clean");
        else
            $display("tb_dht_lookup_router: done, errors");
        $finish;
    end

endmodule
